@@ rtl/rv32ie_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I execute package
// Shared constants, encodings and types of the integer execute unit.
// ----------------------------------------------------------------------------
package rv32ie_pkg;

  localparam int XLEN          = 32;
  localparam int REG_FIELD_W   = 5;
  localparam int REG_COUNT_DEF = 32;

  localparam logic [6:0] OPC_MASK  = 7'h7F;
  localparam logic [6:0] OPC_HALT  = 7'b0000000;
  localparam logic [6:0] OPC_AUIPC = 7'b0010111;
  localparam logic [6:0] OPC_LUI   = 7'b0110111;
  localparam logic [6:0] OPC_OPIMM = 7'b0010011;
  localparam logic [6:0] OPC_OP    = 7'b0110011;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;
  localparam logic [6:0] OPC_JAL   = 7'b1101111;

  localparam logic [6:0] F7_ZERO = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;
  localparam logic [XLEN-1:0] PC_STEP   = 32'd4;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_HALT    = 2'd1,
    STATUS_ILLEGAL = 2'd2
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [XLEN-1:0]        next_pc;
    logic                   write_enable;
    logic [REG_FIELD_W-1:0] write_register;
    logic [XLEN-1:0]        write_value;
    logic                   set_halt;
  } exec_res_t;

endpackage

@@ rtl/rv32ie_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I execute channels
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface rv32ie_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface rv32ie_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] next_pc;
  logic        write_enable;
  logic [4:0]  write_register;
  logic [31:0] write_value;

  modport source (output valid, output status, output next_pc, output write_enable,
                  output write_register, output write_value, input ready);
  modport sink (input valid, input status, input next_pc, input write_enable,
                input write_register, input write_value, output ready);
endinterface

@@ rtl/rv32ie_exec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I execute datapath
// Decodes one instruction and computes its result, next PC and status.
// ----------------------------------------------------------------------------
module rv32ie_exec #(
  parameter int REG_COUNT = rv32ie_pkg::REG_COUNT_DEF
) (
  input  logic [31:0]           instr,
  input  logic [31:0]           pc,
  input  logic                  halted,
  input  logic [31:0]           op_a,
  input  logic [31:0]           op_b,
  output rv32ie_pkg::exec_res_t res
);

  localparam logic [5:0] RegLimit = 6'(REG_COUNT);

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic        rd_ok;
  logic        rs1_ok;
  logic        rs2_ok;
  logic [31:0] imm_i;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [31:0] bsrc;
  logic [4:0]  shamt;
  logic [31:0] pc4;
  logic [31:0] pc_imm;
  logic [31:0] sum;
  logic [31:0] diff;
  logic        lt_s;
  logic        lt_u;
  logic [31:0] sll;
  logic [31:0] srl;
  logic [31:0] sra;
  logic [31:0] val;
  logic [31:0] npc;
  logic        ok;
  logic        is_op;
  rv32ie_pkg::status_t st;

  assign opc    = instr[6:0] & rv32ie_pkg::OPC_MASK;
  assign rd     = instr[11:7];
  assign rs1    = instr[19:15];
  assign rs2    = instr[24:20];
  assign f3     = instr[14:12];
  assign f7     = instr[31:25];
  assign rd_ok  = {1'b0, rd} < RegLimit;
  assign rs1_ok = {1'b0, rs1} < RegLimit;
  assign rs2_ok = {1'b0, rs2} < RegLimit;

  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_u = {instr[31:12], 12'b0};
  assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

  assign is_op  = (opc == rv32ie_pkg::OPC_OP);
  assign bsrc   = is_op ? op_b : imm_i;
  assign shamt  = is_op ? op_b[4:0] : instr[24:20];
  assign pc4    = pc + rv32ie_pkg::PC_STEP;
  assign pc_imm = pc + ((opc == rv32ie_pkg::OPC_JAL) ? imm_j : imm_u);
  assign sum    = op_a + bsrc;
  assign diff   = op_a - op_b;
  assign lt_s   = $signed(op_a) < $signed(bsrc);
  assign lt_u   = op_a < bsrc;
  assign sll    = op_a << shamt;
  assign srl    = op_a >> shamt;
  assign sra    = 32'($signed(op_a) >>> shamt);

  always_comb begin
    val = '0;
    npc = pc4;
    ok  = 1'b1;
    unique case (opc)
      rv32ie_pkg::OPC_LUI: begin
        ok  = rd_ok;
        val = imm_u;
      end
      rv32ie_pkg::OPC_AUIPC: begin
        ok  = rd_ok;
        val = pc_imm;
      end
      rv32ie_pkg::OPC_OPIMM: begin
        ok = rd_ok && rs1_ok;
        unique case (f3)
          rv32ie_pkg::F3_ADD:  val = sum;
          rv32ie_pkg::F3_SLT:  val = {31'b0, lt_s};
          rv32ie_pkg::F3_SLTU: val = {31'b0, lt_u};
          rv32ie_pkg::F3_XOR:  val = op_a ^ bsrc;
          rv32ie_pkg::F3_OR:   val = op_a | bsrc;
          rv32ie_pkg::F3_AND:  val = op_a & bsrc;
          rv32ie_pkg::F3_SLL: begin
            ok  = ok && (f7 == rv32ie_pkg::F7_ZERO);
            val = sll;
          end
          default: begin
            priority if (f7 == rv32ie_pkg::F7_ZERO) begin
              val = srl;
            end else if (f7 == rv32ie_pkg::F7_ALT) begin
              val = sra;
            end else begin
              ok = 1'b0;
            end
          end
        endcase
      end
      rv32ie_pkg::OPC_OP: begin
        ok = rd_ok && rs1_ok && rs2_ok;
        priority if (f7 == rv32ie_pkg::F7_ZERO) begin
          unique case (f3)
            rv32ie_pkg::F3_ADD:  val = sum;
            rv32ie_pkg::F3_SLL:  val = sll;
            rv32ie_pkg::F3_SLT:  val = {31'b0, lt_s};
            rv32ie_pkg::F3_SLTU: val = {31'b0, lt_u};
            rv32ie_pkg::F3_XOR:  val = op_a ^ op_b;
            rv32ie_pkg::F3_SRL:  val = srl;
            rv32ie_pkg::F3_OR:   val = op_a | op_b;
            default:             val = op_a & op_b;
          endcase
        end else if (f7 == rv32ie_pkg::F7_ALT && f3 == rv32ie_pkg::F3_ADD) begin
          val = diff;
        end else if (f7 == rv32ie_pkg::F7_ALT && f3 == rv32ie_pkg::F3_SRL) begin
          val = sra;
        end else begin
          ok = 1'b0;
        end
      end
      rv32ie_pkg::OPC_JAL: begin
        ok  = rd_ok;
        val = pc4;
        npc = pc_imm;
      end
      rv32ie_pkg::OPC_JALR: begin
        ok  = rd_ok && rs1_ok && (f3 == rv32ie_pkg::F3_ADD);
        val = pc4;
        npc = sum & rv32ie_pkg::JALR_MASK;
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    priority if (halted || opc == rv32ie_pkg::OPC_HALT) begin
      st = rv32ie_pkg::STATUS_HALT;
    end else if (!ok) begin
      st = rv32ie_pkg::STATUS_ILLEGAL;
    end else begin
      st = rv32ie_pkg::STATUS_OK;
    end
  end

  always_comb begin
    res.status         = st;
    res.set_halt       = (st == rv32ie_pkg::STATUS_HALT);
    res.next_pc        = (st == rv32ie_pkg::STATUS_OK) ? npc : pc;
    res.write_enable   = (st == rv32ie_pkg::STATUS_OK) && (rd != '0);
    res.write_register = res.write_enable ? rd : '0;
    res.write_value    = res.write_enable ? val : '0;
  end

endmodule

@@ rtl/rv32i_integer_execute_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I integer execute unit
// Executes LUI, AUIPC, OP-IMM, OP, JAL and JALR against a register file.
// ----------------------------------------------------------------------------
// The register file is read into the execute stage when an instruction beat is
// accepted, and the result beat is registered when that stage advances.
// Throughput: one instruction per cycle; a held result beat stalls the input
// once the execute stage is also occupied.
// Reset clears the program counter and the halt flag, and per-entry valid bits
// make every register read as zero until it is written.
module rv32i_integer_execute_unit #(
  parameter int REG_COUNT = rv32ie_pkg::REG_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  rv32ie_in_if.sink     in_ch,
  rv32ie_out_if.source  out_ch
);

  localparam int IdxW = $clog2(REG_COUNT);

  logic [31:0]          rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;

  logic        in_acc;
  logic        s1_adv;
  logic        s1_vld_r;
  logic [31:0] s1_instr_r;
  logic [31:0] rd1_data_r;
  logic [31:0] rd2_data_r;
  logic        rd1_vld_r;
  logic        rd2_vld_r;
  logic        byp_vld_r;
  logic [4:0]  byp_idx_r;
  logic [31:0] byp_data_r;
  logic [31:0] pc_r;
  logic [31:0] pc_nxt;
  logic        halted_r;
  logic        halted_nxt;
  logic        out_vld_r;
  logic        out_vld_nxt;
  logic [1:0]  out_status_r;
  logic [31:0] out_next_pc_r;
  logic        out_we_r;
  logic [4:0]  out_wreg_r;
  logic [31:0] out_wval_r;
  logic [4:0]  s1_rs1;
  logic [4:0]  s1_rs2;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic        wr_en;
  logic [IdxW-1:0] rs1_idx;
  logic [IdxW-1:0] rs2_idx;
  logic [IdxW-1:0] wr_idx;
  rv32ie_pkg::exec_res_t res;

  assign s1_adv       = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign rs1_idx      = in_ch.instruction[15 +: IdxW];
  assign rs2_idx      = in_ch.instruction[20 +: IdxW];
  assign wr_en        = s1_adv && res.write_enable;
  assign wr_idx       = res.write_register[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd1_data_r <= rf_mem[rs1_idx];
      rd2_data_r <= rf_mem[rs2_idx];
      rd1_vld_r  <= rf_vld_r[rs1_idx];
      rd2_vld_r  <= rf_vld_r[rs2_idx];
      s1_instr_r <= in_ch.instruction;
    end
    if (wr_en) begin
      rf_mem[wr_idx] <= res.write_value;
    end
  end

  assign s1_rs1 = s1_instr_r[19:15];
  assign s1_rs2 = s1_instr_r[24:20];

  // The previous beat's write can land in the same edge as this beat's read.
  always_comb begin
    priority if (s1_rs1 == '0) begin
      op_a = '0;
    end else if (byp_vld_r && byp_idx_r == s1_rs1) begin
      op_a = byp_data_r;
    end else begin
      op_a = rd1_vld_r ? rd1_data_r : '0;
    end
    priority if (s1_rs2 == '0) begin
      op_b = '0;
    end else if (byp_vld_r && byp_idx_r == s1_rs2) begin
      op_b = byp_data_r;
    end else begin
      op_b = rd2_vld_r ? rd2_data_r : '0;
    end
  end

  rv32ie_exec #(
    .REG_COUNT (REG_COUNT)
  ) u_exec (
    .instr  (s1_instr_r),
    .pc     (pc_r),
    .halted (halted_r),
    .op_a   (op_a),
    .op_b   (op_b),
    .res    (res)
  );

  always_comb begin
    pc_nxt      = pc_r;
    halted_nxt  = halted_r;
    out_vld_nxt = out_vld_r;
    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (s1_adv) begin
      pc_nxt      = res.next_pc;
      halted_nxt  = halted_r || res.set_halt;
      out_vld_nxt = 1'b1;
    end
    if (cfg_we) begin
      pc_nxt     = cfg_wdata;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r  <= '0;
      s1_vld_r  <= 1'b0;
      byp_vld_r <= 1'b0;
      pc_r      <= '0;
      halted_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        rf_vld_r[wr_idx] <= 1'b1;
        byp_vld_r        <= 1'b1;
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      pc_r      <= pc_nxt;
      halted_r  <= halted_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_idx_r  <= res.write_register;
      byp_data_r <= res.write_value;
    end
    if (s1_adv) begin
      out_status_r  <= res.status;
      out_next_pc_r <= res.next_pc;
      out_we_r      <= res.write_enable;
      out_wreg_r    <= res.write_register;
      out_wval_r    <= res.write_value;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.next_pc        = out_next_pc_r;
  assign out_ch.write_enable   = out_we_r;
  assign out_ch.write_register = out_wreg_r;
  assign out_ch.write_value    = out_wval_r;

  a_halt_sticks : assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && !cfg_we |=> halted_r)
    else $error("halt flag dropped without a start address write");

  a_halted_reports_halt : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && halted_r |-> res.status == rv32ie_pkg::STATUS_HALT && !res.write_enable)
    else $error("instruction executed while halted");

  a_no_x0_write : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> res.write_register != '0)
    else $error("register x0 written");

  a_stall_holds_stage : assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_vld_r && !out_ch.ready |=> s1_vld_r && $stable(s1_instr_r))
    else $error("execute stage lost its beat under back pressure");

endmodule

@@ bench/rv32i_integer_execute_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I integer execute unit testbench
// Drives instruction beats into the execute unit and checks every result beat
// against an instruction-level predictor with its own register file and PC, or
// fixed row values. Directed rows cover every operation, immediate extremes,
// halt, illegal encodings and start address loads. Random phases follow, each
// with a new start address, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module rv32i_integer_execute_unit_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 110;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    rv32ie_pkg::status_t status;
    logic [31:0]         next_pc;
    logic                write_enable;
    logic [4:0]          write_register;
    logic [31:0]         write_value;
  } retire_t;

  typedef struct {
    bit          cfg_wr;
    logic [31:0] cfg_val;
    logic [31:0] instr;
    bit          typed;
    retire_t     known;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  rv32ie_in_if in_ch();
  rv32ie_out_if out_ch();

  rv32i_integer_execute_unit #(.REG_COUNT(32)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  logic [31:0] gpr [32];
  logic [31:0] pc_q;
  logic        halted_q;

  retire_t   pending_retires[$];
  stim_row_t dir_tab[$];

  int  cyc = 0;
  int  errors = 0;
  int  beats_sent = 0;
  int  n_exec = 0;
  int  n_halt = 0;
  int  n_illegal = 0;
  int  n_cfg = 0;
  logic calm = 1'b0;
  logic hold_off_req = 1'b0;
  bit   hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rv32ie_pkg::OPC_OP};
  endfunction

  function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  function automatic stim_row_t row_p(logic [31:0] w);
    stim_row_t r;
    r.cfg_wr = 1'b0;
    r.cfg_val = '0;
    r.instr = w;
    r.typed = 1'b0;
    r.known = '0;
    return r;
  endfunction

  function automatic stim_row_t row_k(bit cfg, logic [31:0] cval, logic [31:0] w,
                                      rv32ie_pkg::status_t st, logic [31:0] npc, logic we,
                                      logic [4:0] wr, logic [31:0] wv);
    stim_row_t r;
    r.cfg_wr = cfg;
    r.cfg_val = cval;
    r.instr = w;
    r.typed = 1'b1;
    r.known.status = st;
    r.known.next_pc = npc;
    r.known.write_enable = we;
    r.known.write_register = wr;
    r.known.write_value = wv;
    return r;
  endfunction

  function automatic retire_t retire_instruction(logic [31:0] w);
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] val;
    logic [31:0] npc;
    logic        ok;
    retire_t     r;
    opc = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = gpr[w[19:15]];
    b = gpr[w[24:20]];
    imm = {{20{w[31]}}, w[31:20]};
    npc = pc_q + rv32ie_pkg::PC_STEP;
    val = '0;
    ok = 1'b1;
    r = '0;
    r.status = rv32ie_pkg::STATUS_OK;
    if (halted_q || opc == rv32ie_pkg::OPC_HALT) begin
      halted_q = 1'b1;
      r.status = rv32ie_pkg::STATUS_HALT;
    end else begin
      case (opc)
        rv32ie_pkg::OPC_LUI: val = {w[31:12], 12'b0};
        rv32ie_pkg::OPC_AUIPC: val = {w[31:12], 12'b0} + pc_q;
        rv32ie_pkg::OPC_OPIMM: begin
          case (f3)
            rv32ie_pkg::F3_ADD: val = a + imm;
            rv32ie_pkg::F3_SLT: val = {31'b0, $signed(a) < $signed(imm)};
            rv32ie_pkg::F3_SLTU: val = {31'b0, a < imm};
            rv32ie_pkg::F3_XOR: val = a ^ imm;
            rv32ie_pkg::F3_OR: val = a | imm;
            rv32ie_pkg::F3_AND: val = a & imm;
            rv32ie_pkg::F3_SLL: begin
              ok = (f7 == rv32ie_pkg::F7_ZERO);
              val = a << imm[4:0];
            end
            default: begin
              if (f7 == rv32ie_pkg::F7_ZERO) val = a >> imm[4:0];
              else if (f7 == rv32ie_pkg::F7_ALT) val = $signed(a) >>> imm[4:0];
              else ok = 1'b0;
            end
          endcase
        end
        rv32ie_pkg::OPC_OP: begin
          if (f7 == rv32ie_pkg::F7_ZERO) begin
            case (f3)
              rv32ie_pkg::F3_ADD: val = a + b;
              rv32ie_pkg::F3_SLL: val = a << b[4:0];
              rv32ie_pkg::F3_SLT: val = {31'b0, $signed(a) < $signed(b)};
              rv32ie_pkg::F3_SLTU: val = {31'b0, a < b};
              rv32ie_pkg::F3_XOR: val = a ^ b;
              rv32ie_pkg::F3_SRL: val = a >> b[4:0];
              rv32ie_pkg::F3_OR: val = a | b;
              default: val = a & b;
            endcase
          end else if (f7 == rv32ie_pkg::F7_ALT && f3 == rv32ie_pkg::F3_ADD) begin
            val = a - b;
          end else if (f7 == rv32ie_pkg::F7_ALT && f3 == rv32ie_pkg::F3_SRL) begin
            val = $signed(a) >>> b[4:0];
          end else begin
            ok = 1'b0;
          end
        end
        rv32ie_pkg::OPC_JAL: begin
          val = pc_q + rv32ie_pkg::PC_STEP;
          npc = pc_q + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        rv32ie_pkg::OPC_JALR: begin
          ok = (f3 == rv32ie_pkg::F3_ADD);
          val = pc_q + rv32ie_pkg::PC_STEP;
          npc = (a + imm) & rv32ie_pkg::JALR_MASK;
        end
        default: ok = 1'b0;
      endcase
      if (!ok) r.status = rv32ie_pkg::STATUS_ILLEGAL;
    end
    if (r.status != rv32ie_pkg::STATUS_OK) begin
      r.next_pc = pc_q;
    end else begin
      pc_q = npc;
      r.next_pc = npc;
      if (rd != 5'd0) begin
        gpr[rd] = val;
        r.write_enable = 1'b1;
        r.write_register = rd;
        r.write_value = val;
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] pick_funct7();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return rv32ie_pkg::F7_ZERO;
    if (sel < 9) return rv32ie_pkg::F7_ALT;
    return 7'($urandom);
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    int sel;
    w = $urandom;
    sel = $urandom_range(99);
    if ($urandom_range(1) == 0) begin
      w[11:7] = 5'($urandom_range(7));
      w[19:15] = 5'($urandom_range(7));
      w[24:20] = 5'($urandom_range(7));
    end
    if (sel < 30) begin
      w[6:0] = rv32ie_pkg::OPC_OPIMM;
      if (w[14:12] == rv32ie_pkg::F3_SLL || w[14:12] == rv32ie_pkg::F3_SRL) begin
        w[31:25] = pick_funct7();
      end
    end else if (sel < 60) begin
      w[6:0] = rv32ie_pkg::OPC_OP;
      w[31:25] = pick_funct7();
    end else if (sel < 66) begin
      w[6:0] = rv32ie_pkg::OPC_LUI;
    end else if (sel < 72) begin
      w[6:0] = rv32ie_pkg::OPC_AUIPC;
    end else if (sel < 80) begin
      w[6:0] = rv32ie_pkg::OPC_JAL;
    end else if (sel < 90) begin
      w[6:0] = rv32ie_pkg::OPC_JALR;
      if ($urandom_range(9) != 0) w[14:12] = rv32ie_pkg::F3_ADD;
    end else if (w[6:0] == rv32ie_pkg::OPC_HALT) begin
      w[0] = 1'b1;
    end
    if ($urandom_range(249) == 0) w[6:0] = rv32ie_pkg::OPC_HALT;
    return w;
  endfunction

  task automatic send_instr(input logic [31:0] w, input bit typed, input retire_t known);
    retire_t r;
    in_ch.valid <= 1'b1;
    in_ch.instruction <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = retire_instruction(w);
    pending_retires.push_back(typed ? known : r);
    beats_sent++;
    while (!calm && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic load_start_address(input logic [31:0] addr);
    in_ch.valid <= 1'b0;
    while (pending_retires.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    pc_q = addr;
    halted_q = 1'b0;
    n_cfg++;
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    retire_t e;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_retires.size() == 0) begin
        $error("result beat with no instruction outstanding");
        errors++;
      end else begin
        e = pending_retires.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          errors++;
        end
        if (out_ch.next_pc !== e.next_pc) begin
          $error("next_pc: expected %h, got %h", e.next_pc, out_ch.next_pc);
          errors++;
        end
        if (out_ch.write_enable !== e.write_enable) begin
          $error("write_enable: expected %0d, got %0d", e.write_enable, out_ch.write_enable);
          errors++;
        end
        if (out_ch.write_register !== e.write_register) begin
          $error("write_register: expected %0d, got %0d", e.write_register,
                 out_ch.write_register);
          errors++;
        end
        if (out_ch.write_value !== e.write_value) begin
          $error("write_value: expected %h, got %h", e.write_value, out_ch.write_value);
          errors++;
        end
        case (e.status)
          rv32ie_pkg::STATUS_OK: n_exec++;
          rv32ie_pkg::STATUS_HALT: n_halt++;
          default: n_illegal++;
        endcase
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin
    logic [31:0] starts [PHASES];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.instruction <= '0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    pc_q = '0;
    halted_q = 1'b0;

    dir_tab.push_back(row_k(0, 0, enc_u(20'hFFFFF, 1, rv32ie_pkg::OPC_LUI),
                            rv32ie_pkg::STATUS_OK, 32'h4, 1, 1, 32'hFFFF_F000));
    dir_tab.push_back(row_k(0, 0, enc_u(20'h80000, 2, rv32ie_pkg::OPC_AUIPC),
                            rv32ie_pkg::STATUS_OK, 32'h8, 1, 2, 32'h8000_0004));
    dir_tab.push_back(row_k(0, 0, enc_i(12'h800, 0, rv32ie_pkg::F3_ADD, 3,
                                        rv32ie_pkg::OPC_OPIMM),
                            rv32ie_pkg::STATUS_OK, 32'hC, 1, 3, 32'hFFFF_F800));
    dir_tab.push_back(row_k(0, 0, enc_i(12'h7FF, 0, rv32ie_pkg::F3_ADD, 4,
                                        rv32ie_pkg::OPC_OPIMM),
                            rv32ie_pkg::STATUS_OK, 32'h10, 1, 4, 32'h7FF));
    dir_tab.push_back(row_p(enc_i(12'hFFF, 3, rv32ie_pkg::F3_SLT, 5, rv32ie_pkg::OPC_OPIMM)));
    dir_tab.push_back(row_p(enc_i(12'hFFF, 4, rv32ie_pkg::F3_SLTU, 6, rv32ie_pkg::OPC_OPIMM)));
    dir_tab.push_back(row_p(enc_i(12'h555, 1, rv32ie_pkg::F3_XOR, 7, rv32ie_pkg::OPC_OPIMM)));
    dir_tab.push_back(row_p(enc_i(12'hF00, 2, rv32ie_pkg::F3_OR, 8, rv32ie_pkg::OPC_OPIMM)));
    dir_tab.push_back(row_p(enc_i(12'h7F0, 1, rv32ie_pkg::F3_AND, 9, rv32ie_pkg::OPC_OPIMM)));
    dir_tab.push_back(row_p(enc_i(12'h01F, 4, rv32ie_pkg::F3_SLL, 10, rv32ie_pkg::OPC_OPIMM)));
    dir_tab.push_back(row_p(enc_i(12'h004, 1, rv32ie_pkg::F3_SRL, 11, rv32ie_pkg::OPC_OPIMM)));
    dir_tab.push_back(row_p(enc_i({rv32ie_pkg::F7_ALT, 5'd31}, 1, rv32ie_pkg::F3_SRL, 12,
                                  rv32ie_pkg::OPC_OPIMM)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ZERO, 2, 1, rv32ie_pkg::F3_ADD, 13)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ALT, 1, 3, rv32ie_pkg::F3_ADD, 0)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ZERO, 4, 1, rv32ie_pkg::F3_SLL, 14)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ZERO, 4, 3, rv32ie_pkg::F3_SLT, 15)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ZERO, 4, 3, rv32ie_pkg::F3_SLTU, 16)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ZERO, 3, 1, rv32ie_pkg::F3_XOR, 17)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ZERO, 4, 1, rv32ie_pkg::F3_SRL, 18)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ALT, 4, 1, rv32ie_pkg::F3_SRL, 19)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ZERO, 4, 2, rv32ie_pkg::F3_OR, 20)));
    dir_tab.push_back(row_p(enc_r(rv32ie_pkg::F7_ZERO, 3, 1, rv32ie_pkg::F3_AND, 21)));
    dir_tab.push_back(row_p({1'b1, 10'd0, 1'b0, 8'hFF, 5'd22, rv32ie_pkg::OPC_JAL}));
    dir_tab.push_back(row_p(enc_i(12'hFFE, 4, rv32ie_pkg::F3_ADD, 23, rv32ie_pkg::OPC_JALR)));
    dir_tab.push_back(row_p(enc_i(12'h000, 1, rv32ie_pkg::F3_SLL, 24, rv32ie_pkg::OPC_JALR)));
    dir_tab.push_back(row_p(enc_i({7'h10, 5'd3}, 1, rv32ie_pkg::F3_SRL, 25,
                                  rv32ie_pkg::OPC_OPIMM)));
    dir_tab.push_back(row_p(32'hFFFF_FFFF));
    dir_tab.push_back(row_k(1, 32'hFFFF_FFFC, 32'h0, rv32ie_pkg::STATUS_HALT, 32'hFFFF_FFFC,
                            0, 0, 0));
    dir_tab.push_back(row_k(0, 0, enc_i(12'h001, 0, rv32ie_pkg::F3_ADD, 5,
                                        rv32ie_pkg::OPC_OPIMM),
                            rv32ie_pkg::STATUS_HALT, 32'hFFFF_FFFC, 0, 0, 0));
    dir_tab.push_back(row_k(1, 32'hFFFF_FFFC, enc_i(12'h000, 0, rv32ie_pkg::F3_ADD, 0,
                                                    rv32ie_pkg::OPC_OPIMM),
                            rv32ie_pkg::STATUS_OK, 32'h0, 0, 0, 0));
    dir_tab.push_back(row_k(1, 32'hFFFF_FFFF, enc_u(20'h0, 24, rv32ie_pkg::OPC_AUIPC),
                            rv32ie_pkg::STATUS_OK, 32'h3, 1, 24, 32'hFFFF_FFFF));

    starts[0] = 32'h0;
    starts[1] = 32'hFFFF_FFFF;
    starts[2] = 32'h8000_0000;
    starts[3] = 32'h7FFF_FFFC;
    for (int p = 4; p < PHASES; p++) starts[p] = $urandom;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_wr) load_start_address(dir_tab[i].cfg_val);
      send_instr(dir_tab[i].instr, dir_tab[i].typed, dir_tab[i].known);
    end

    for (int p = 0; p < PHASES; p++) begin
      load_start_address(starts[p]);
      calm <= (p == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 40) hold_off_req <= 1'b1;
        send_instr(random_instruction(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    calm <= 1'b0;
    while (pending_retires.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Retired %0d instruction beats: %0d executed, %0d halted, %0d illegal.",
             beats_sent, n_exec, n_halt, n_illegal);
    $display("Programmed %0d start addresses and held off results for %0d cycles once.",
             n_cfg, HOLD_CYCLES);
    if (errors == 0 && pending_retires.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rv32ie_pkg.sv
rtl/rv32ie_if.sv
rtl/rv32ie_exec.sv
rtl/rv32i_integer_execute_unit.sv
bench/rv32i_integer_execute_unit_tb.sv
